FILE: src/gate_mode_controller_core_macros.svh
`ifndef GATE_MODE_CONTROLLER_CORE_MACROS_SVH
`define GATE_MODE_CONTROLLER_CORE_MACROS_SVH

// Property checked at every clock edge outside reset
`define GMC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition at one edge implies a consequence at the next edge
`define GMC_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

FILE: src/gmc_pkg.sv
package gmc_pkg;

    localparam int MAX_GATES_DEF = 15;
    localparam int CFG_ADDR_W    = 5;
    localparam int CFG_DATA_W    = 32;
    localparam int IN_DATA_W     = 64;
    localparam int IN_USER_W     = 2;
    localparam int OUT_DATA_W    = 16;

    // register indexes
    localparam logic [2:0] REG_LONG_PRESS   = 3'd0;
    localparam logic [2:0] REG_CRIT_PRESS   = 3'd1;
    localparam logic [2:0] REG_GATE_COUNT   = 3'd2;
    localparam logic [2:0] REG_FIX_GAP      = 3'd3;
    localparam logic [2:0] REG_STABLE_TGT   = 3'd4;
    localparam logic [2:0] REG_SWITCH_THR   = 3'd5;
    localparam logic [2:0] REG_AUTOSLEEP    = 3'd6;

    // item kinds
    localparam logic [1:0] FUNC_BUTTON = 2'd0;
    localparam logic [1:0] FUNC_FIX    = 2'd1;
    localparam logic [1:0] FUNC_REVERT = 2'd2;
    localparam logic [1:0] FUNC_WAKE   = 2'd3;

    // modes
    localparam logic [1:0] MODE_UNFIXED = 2'd0;
    localparam logic [1:0] MODE_FIXED   = 2'd1;
    localparam logic [1:0] MODE_MANUAL  = 2'd2;
    localparam logic [1:0] MODE_SLEEP   = 2'd3;

    localparam logic [4:0] SLEEP_CODE = 5'd16;

    typedef struct packed {
        logic [15:0] long_press_ms;
        logic [15:0] crit_press_ms;
        logic [3:0]  gate_count;
        logic [15:0] fix_gap_ms;
        logic [7:0]  stable_target;
        logic [7:0]  switch_threshold;
        logic [23:0] autosleep_dist_m;
    } cfg_t;

    localparam cfg_t CFG_RESET = '{
        long_press_ms:    16'd1000,
        crit_press_ms:    16'd5000,
        gate_count:       4'd2,
        fix_gap_ms:       16'd2500,
        stable_target:    8'd3,
        switch_threshold: 8'd3,
        autosleep_dist_m: 24'd1000
    };

    typedef struct packed {
        logic [1:0]  func;
        logic [23:0] nearest_dist_m;
        logic [3:0]  nearest_gate;
        logic        button_level;
        logic [31:0] now_ms;
    } item_t;

    localparam int ITEM_DATA_W = $bits(item_t) - IN_USER_W;

    typedef struct packed {
        logic       gate_changed;
        logic       sleep_request;
        logic       stamp_status;
        logic       mode_changed;
        logic [1:0] mode;
        logic [3:0] current_gate;
        logic [3:0] rc_gate;
    } result_t;

endpackage

FILE: src/gate_mode_controller_core.sv
// Mode controller for a position-driven remote. Each s_ transfer carries a button sample, a GPS
// fix, a manual-revert request or a wake event (s_tuser), and produces exactly one m_ transfer
// with the gate to transmit to, the selected gate, the mode and event flags. An item is held in
// the input register, then in the result register; the decision logic between them updates the
// controller state as it moves on, so a new item is taken every cycle unless m_tready stalls.
// Thresholds are set through the APB port and must be written while idle; this is not enforced.
module gate_mode_controller_core
#(
    parameter int MAX_GATES = gmc_pkg::MAX_GATES_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [gmc_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [gmc_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [gmc_pkg::CFG_DATA_W-1:0] prdata,
    output logic                           pready,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // now_ms[31:0], button_level[32], nearest_gate[36:33], nearest_dist_m[60:37]
    input  logic [gmc_pkg::IN_DATA_W-1:0]  s_tdata,
    // func[1:0]
    input  logic [gmc_pkg::IN_USER_W-1:0]  s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // rc_gate[3:0], current_gate[7:4], mode[9:8], mode_changed[10],
    // stamp_status[11], sleep_request[12], gate_changed[13]
    output logic [gmc_pkg::OUT_DATA_W-1:0] m_tdata
);

    gmc_pkg::cfg_t    cfg;
    gmc_pkg::item_t   in_item_reg;
    gmc_pkg::result_t res;
    gmc_pkg::result_t out_res_reg;
    logic             in_valid_reg, in_valid_next;
    logic             out_valid_reg, out_valid_next;
    logic             advance;
    logic             s_xfer;

    gmc_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    gmc_ctrl #(
        .MAX_GATES (MAX_GATES)
    ) u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .step  (advance),
        .item  (in_item_reg),
        .res   (res)
    );

    assign advance        = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready       = !in_valid_reg || advance;
    assign s_xfer         = s_tvalid && s_tready;
    assign in_valid_next  = s_xfer || (in_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && !m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_xfer)
            in_item_reg <= {s_tuser, s_tdata[gmc_pkg::ITEM_DATA_W-1:0]};
        if (advance)
            out_res_reg <= res;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(gmc_pkg::OUT_DATA_W - $bits(gmc_pkg::result_t)){1'b0}}, out_res_reg};

endmodule

FILE: src/gmc_cfg.sv
module gmc_cfg
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [gmc_pkg::CFG_ADDR_W-1:0] paddr,
    input  logic [gmc_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [gmc_pkg::CFG_DATA_W-1:0] prdata,
    output logic                          pready,
    output gmc_pkg::cfg_t                 cfg
);

    gmc_pkg::cfg_t cfg_reg;
    logic [2:0]    idx;
    logic          wr_en;

    assign idx    = paddr[4:2];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= gmc_pkg::CFG_RESET;
        end
        else if (wr_en)
        begin
            unique case (idx)
                gmc_pkg::REG_LONG_PRESS: cfg_reg.long_press_ms    <= pwdata[15:0];
                gmc_pkg::REG_CRIT_PRESS: cfg_reg.crit_press_ms    <= pwdata[15:0];
                gmc_pkg::REG_GATE_COUNT: cfg_reg.gate_count       <= pwdata[3:0];
                gmc_pkg::REG_FIX_GAP:    cfg_reg.fix_gap_ms       <= pwdata[15:0];
                gmc_pkg::REG_STABLE_TGT: cfg_reg.stable_target    <= pwdata[7:0];
                gmc_pkg::REG_SWITCH_THR: cfg_reg.switch_threshold <= pwdata[7:0];
                gmc_pkg::REG_AUTOSLEEP:  cfg_reg.autosleep_dist_m <= pwdata[23:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            gmc_pkg::REG_LONG_PRESS: prdata = {16'd0, cfg_reg.long_press_ms};
            gmc_pkg::REG_CRIT_PRESS: prdata = {16'd0, cfg_reg.crit_press_ms};
            gmc_pkg::REG_GATE_COUNT: prdata = {28'd0, cfg_reg.gate_count};
            gmc_pkg::REG_FIX_GAP:    prdata = {16'd0, cfg_reg.fix_gap_ms};
            gmc_pkg::REG_STABLE_TGT: prdata = {24'd0, cfg_reg.stable_target};
            gmc_pkg::REG_SWITCH_THR: prdata = {24'd0, cfg_reg.switch_threshold};
            gmc_pkg::REG_AUTOSLEEP:  prdata = {8'd0, cfg_reg.autosleep_dist_m};
            default:                 prdata = '0;
        endcase
    end

endmodule

FILE: src/gmc_ctrl.sv
`include "gate_mode_controller_core_macros.svh"

module gmc_ctrl
#(
    parameter int MAX_GATES = gmc_pkg::MAX_GATES_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  gmc_pkg::cfg_t    cfg,
    input  logic             step,
    input  gmc_pkg::item_t   item,
    output gmc_pkg::result_t res
);

    localparam logic [3:0] MaxGates = 4'(MAX_GATES);

    logic [1:0]  mode_reg, mode_next;
    logic        was_fixed_reg, was_fixed_next;
    logic [3:0]  gate_reg, gate_next;
    logic        press_active_reg, press_active_next;
    logic        press_long_reg, press_long_next;
    logic        press_crit_reg, press_crit_next;
    logic [31:0] press_start_reg, press_start_next;
    logic [31:0] last_fix_reg, last_fix_next;
    logic [7:0]  stable_count_reg, stable_count_next;
    logic [4:0]  switch_cand_reg, switch_cand_next;
    logic [7:0]  switch_count_reg, switch_count_next;

    logic [3:0]  eff_gates;
    logic [3:0]  cycled_gate;
    logic [31:0] held;
    logic [31:0] fix_gap;
    logic        close_fix;
    logic [7:0]  stable_upd;
    logic [4:0]  cand;
    logic [7:0]  count_inc;
    logic [1:0]  mode_fix;

    always_comb
    begin
        if (cfg.gate_count > MaxGates)
            eff_gates = MaxGates;
        else if (cfg.gate_count == 4'd0)
            eff_gates = 4'd1;
        else
            eff_gates = cfg.gate_count;
    end

    assign cycled_gate = (gate_reg >= eff_gates) ? 4'd1 : gate_reg + 4'd1;
    assign held        = item.now_ms - (press_active_reg ? press_start_reg : item.now_ms);
    assign fix_gap     = item.now_ms - last_fix_reg;
    assign close_fix   = fix_gap < {16'd0, cfg.fix_gap_ms};
    assign stable_upd  = close_fix ? stable_count_reg + 8'd1 : 8'd0;
    assign cand        = (item.nearest_dist_m < cfg.autosleep_dist_m) ?
                         {1'b0, item.nearest_gate} : gmc_pkg::SLEEP_CODE;
    assign count_inc   = (switch_count_reg == 8'hFF) ? 8'hFF : switch_count_reg + 8'd1;

    always_comb
    begin
        mode_next         = mode_reg;
        was_fixed_next    = was_fixed_reg;
        gate_next         = gate_reg;
        press_active_next = press_active_reg;
        press_long_next   = press_long_reg;
        press_crit_next   = press_crit_reg;
        press_start_next  = press_start_reg;
        last_fix_next     = last_fix_reg;
        stable_count_next = stable_count_reg;
        switch_cand_next  = switch_cand_reg;
        switch_count_next = switch_count_reg;
        mode_fix          = mode_reg;
        res               = '0;

        if (step)
        begin
            if (mode_reg == gmc_pkg::MODE_SLEEP)
            begin
                if (item.func == gmc_pkg::FUNC_WAKE)
                begin
                    mode_next         = gmc_pkg::MODE_UNFIXED;
                    res.mode_changed  = 1'b1;
                    res.stamp_status  = 1'b1;
                    res.gate_changed  = 1'b1;
                end
            end
            else
            begin
                case (item.func)
                    gmc_pkg::FUNC_BUTTON:
                    begin
                        if (item.button_level)
                        begin
                            press_active_next = 1'b1;
                            if (!press_active_reg)
                                press_start_next = item.now_ms;
                            if (held > {16'd0, cfg.long_press_ms} && !press_long_reg)
                            begin
                                press_long_next = 1'b1;
                                if (mode_reg == gmc_pkg::MODE_FIXED)
                                begin
                                    was_fixed_next   = 1'b1;
                                    mode_next        = gmc_pkg::MODE_MANUAL;
                                    res.mode_changed = 1'b1;
                                    res.stamp_status = 1'b1;
                                end
                                else if (mode_reg == gmc_pkg::MODE_MANUAL)
                                begin
                                    res.stamp_status = 1'b1;
                                end
                                gate_next        = cycled_gate;
                                res.gate_changed = 1'b1;
                            end
                            if (!press_crit_reg && held > {16'd0, cfg.crit_press_ms})
                            begin
                                press_crit_next   = 1'b1;
                                mode_next         = gmc_pkg::MODE_SLEEP;
                                res.mode_changed  = 1'b1;
                                res.stamp_status  = 1'b1;
                                res.sleep_request = 1'b1;
                            end
                        end
                        else if (press_active_reg)
                        begin
                            if (press_long_reg)
                            begin
                                press_long_next = 1'b0;
                            end
                            else
                            begin
                                res.rc_gate = gate_reg;
                                if (mode_reg == gmc_pkg::MODE_MANUAL)
                                    res.stamp_status = 1'b1;
                            end
                            press_crit_next   = 1'b0;
                            press_active_next = 1'b0;
                        end
                    end
                    gmc_pkg::FUNC_FIX:
                    begin
                        if (mode_reg == gmc_pkg::MODE_UNFIXED)
                        begin
                            stable_count_next = stable_upd;
                            if (stable_upd == cfg.stable_target)
                            begin
                                mode_fix         = gmc_pkg::MODE_FIXED;
                                res.mode_changed = 1'b1;
                                res.stamp_status = 1'b1;
                            end
                        end
                        mode_next     = mode_fix;
                        last_fix_next = item.now_ms;

                        if (cand != switch_cand_reg)
                        begin
                            switch_cand_next  = cand;
                            switch_count_next = 8'd0;
                        end
                        else if (count_inc < cfg.switch_threshold)
                        begin
                            switch_count_next = count_inc;
                        end
                        else
                        begin
                            switch_count_next = cfg.switch_threshold;
                            if (mode_fix != gmc_pkg::MODE_MANUAL && cand != {1'b0, gate_reg})
                            begin
                                if (cand == gmc_pkg::SLEEP_CODE)
                                begin
                                    mode_next         = gmc_pkg::MODE_SLEEP;
                                    res.mode_changed  = 1'b1;
                                    res.stamp_status  = 1'b1;
                                    res.sleep_request = 1'b1;
                                end
                                else if (cand[3:0] != 4'd0 && cand[3:0] <= eff_gates)
                                begin
                                    gate_next        = cand[3:0];
                                    res.gate_changed = 1'b1;
                                end
                            end
                        end
                    end
                    gmc_pkg::FUNC_REVERT:
                    begin
                        mode_next        = was_fixed_reg ? gmc_pkg::MODE_FIXED :
                                                           gmc_pkg::MODE_UNFIXED;
                        res.mode_changed = 1'b1;
                        res.stamp_status = 1'b1;
                    end
                    default: ;
                endcase
            end
        end

        res.current_gate = gate_next;
        res.mode         = mode_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg         <= gmc_pkg::MODE_UNFIXED;
            was_fixed_reg    <= 1'b0;
            gate_reg         <= 4'd1;
            press_active_reg <= 1'b0;
            press_long_reg   <= 1'b0;
            press_crit_reg   <= 1'b0;
            press_start_reg  <= '0;
            last_fix_reg     <= '0;
            stable_count_reg <= '0;
            switch_cand_reg  <= '0;
            switch_count_reg <= '0;
        end
        else
        begin
            mode_reg         <= mode_next;
            was_fixed_reg    <= was_fixed_next;
            gate_reg         <= gate_next;
            press_active_reg <= press_active_next;
            press_long_reg   <= press_long_next;
            press_crit_reg   <= press_crit_next;
            press_start_reg  <= press_start_next;
            last_fix_reg     <= last_fix_next;
            stable_count_reg <= stable_count_next;
            switch_cand_reg  <= switch_cand_next;
            switch_count_reg <= switch_count_next;
        end
    end

    `GMC_ASSERT(a_gate_in_range, gate_reg != 4'd0 && gate_reg <= MaxGates, "gate out of range")
    `GMC_ASSERT(a_sleep_req_mode, !res.sleep_request || res.mode == gmc_pkg::MODE_SLEEP, "sleep request without sleep mode")
    `GMC_ASSERT(a_mode_chg_stamp, !res.mode_changed || res.stamp_status, "mode update without stamp")
    `GMC_ASSERT_NEXT(a_sleep_frozen, step && mode_reg == gmc_pkg::MODE_SLEEP && item.func != gmc_pkg::FUNC_WAKE, $stable(gate_reg) && $stable(mode_reg) && $stable(press_active_reg), "state moved while asleep")

endmodule
